### src/bfp_pkg.sv
// Package for the branch flow predecoder: flow class codes, opcode patterns
// and the decode result struct shared by the decoder and the top level.
// Depends on nothing.
package bfp_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned ADDR_W = 22;
  localparam int unsigned OFFS_W = 6;

  // Flow class codes as they appear on the flow_class port.
  typedef enum logic [2:0] {
    FLOW_NONE = 3'd0,
    FLOW_JUMP = 3'd1,
    FLOW_COND = 3'd2,
    FLOW_RET  = 3'd3,
    FLOW_CALL = 3'd4
  } flow_class_t;

  // Short relative jumps: opcode field in the upper nine bits.
  localparam logic [WORD_W-1:0] SHORT_MASK = 16'hFF80;
  localparam logic [WORD_W-1:0] JMP_SHORT  = 16'hEE00;
  localparam logic [WORD_W-1:0] COND_0     = 16'h0E00;
  localparam logic [WORD_W-1:0] COND_4     = 16'h4E00;
  localparam logic [WORD_W-1:0] COND_5     = 16'h5E00;
  localparam logic [WORD_W-1:0] COND_7     = 16'h7E00;
  localparam logic [WORD_W-1:0] COND_9     = 16'h9E00;
  localparam logic [WORD_W-1:0] COND_B     = 16'hBE00;

  // Returns from subroutine and from interrupt.
  localparam logic [WORD_W-1:0] RET_SUB    = 16'h9A90;
  localparam logic [WORD_W-1:0] RET_INT    = 16'h9A98;

  // Long jump within the 64K-word page of the next address.
  localparam logic [WORD_W-1:0] JMP_LONG   = 16'h9F0F;

  // Call and goto carry six high target bits in the instruction.
  localparam logic [WORD_W-1:0] CALL_MASK  = 16'hF1C0;
  localparam logic [WORD_W-1:0] CALL_CODE  = 16'hF040;
  localparam logic [WORD_W-1:0] GOTO_MASK  = 16'hFFC0;
  localparam logic [WORD_W-1:0] GOTO_CODE  = 16'hFE80;

  // One decoded result beat.
  typedef struct packed {
    flow_class_t       flow_class;
    logic              target_valid;
    logic [ADDR_W-1:0] target;
  } bfp_result_t;

endpackage

### src/bfp_decode.sv
// Combinational control-flow decoder for one instruction word.
// Depends on bfp_pkg for the opcode patterns and the result struct.
module bfp_decode
  import bfp_pkg::*;
(
  input  logic [WORD_W-1:0] instr_word,
  input  logic [ADDR_W-1:0] instr_address,
  input  logic [WORD_W-1:0] next_word,
  input  logic              next_present,
  output bfp_result_t       result
);

  logic [ADDR_W-1:0] next_addr;
  logic [ADDR_W-1:0] offset;
  logic [ADDR_W-1:0] short_target;
  logic [ADDR_W-1:0] long_target;
  logic [ADDR_W-1:0] call_target;
  logic [WORD_W-1:0] short_op;
  logic              is_cond;

  // Address of the following word, wrapping at the top of the space.
  assign next_addr = instr_address + ADDR_W'(1);

  // Short target: bit 6 selects a backward step.
  assign offset       = ADDR_W'(instr_word[OFFS_W-1:0]);
  assign short_target = instr_word[OFFS_W] ? (next_addr - offset) : (next_addr + offset);

  // Long jump keeps the page of the next address; call and goto take their
  // page from the instruction.
  assign long_target = {next_addr[ADDR_W-1:WORD_W], next_word};
  assign call_target = {instr_word[OFFS_W-1:0], next_word};

  assign short_op = instr_word & SHORT_MASK;
  assign is_cond  = (short_op == COND_0) || (short_op == COND_4) || (short_op == COND_5) ||
                    (short_op == COND_7) || (short_op == COND_9) || (short_op == COND_B);

  // Priority decode, first match wins.
  always_comb begin
    result.flow_class   = FLOW_NONE;
    result.target_valid = 1'b0;
    result.target       = '0;
    if (short_op == JMP_SHORT) begin
      result.flow_class   = FLOW_JUMP;
      result.target_valid = 1'b1;
      result.target       = short_target;
    end else if (is_cond) begin
      result.flow_class   = FLOW_COND;
      result.target_valid = 1'b1;
      result.target       = short_target;
    end else if ((instr_word == RET_SUB) || (instr_word == RET_INT)) begin
      result.flow_class = FLOW_RET;
    end else if (instr_word == JMP_LONG) begin
      result.flow_class = FLOW_JUMP;
      if (next_present) begin
        result.target_valid = 1'b1;
        result.target       = long_target;
      end
    end else if ((instr_word & CALL_MASK) == CALL_CODE) begin
      result.flow_class = FLOW_CALL;
      if (next_present) begin
        result.target_valid = 1'b1;
        result.target       = call_target;
      end
    end else if ((instr_word & GOTO_MASK) == GOTO_CODE) begin
      result.flow_class = FLOW_JUMP;
      if (next_present) begin
        result.target_valid = 1'b1;
        result.target       = call_target;
      end
    end
  end

endmodule

### src/branch_flow_predecode.sv
// Top level of the branch flow predecoder: input register, decoder and
// result register with valid/ready on both sides.
// Depends on bfp_pkg and bfp_decode.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------------
//   in      | input     | in_valid / in_ready   | instr_word, instr_address, next_word, next_present
//   out     | output    | out_valid / out_ready | flow_class, target_valid, target_word_address
//
// One beat is accepted every cycle unless the output stalls; each result
// passes through the input register and then the result register.
// Reset clears only the two valid flags; the data registers are not reset.
// When the output stalls, the input register still takes one more beat,
// and in_ready drops only when both registers hold waiting beats.
module branch_flow_predecode
  import bfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WORD_W-1:0] instr_word,
  input  logic [ADDR_W-1:0] instr_address,
  input  logic [WORD_W-1:0] next_word,
  input  logic              next_present,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        flow_class,
  output logic              target_valid,
  output logic [ADDR_W-1:0] target_word_address
);

  logic              s1_valid;
  logic [WORD_W-1:0] s1_word;
  logic [ADDR_W-1:0] s1_address;
  logic [WORD_W-1:0] s1_next_word;
  logic              s1_next_present;
  logic              s1_advance;
  bfp_result_t       dec_result;
  bfp_result_t       out_result;

  // Stage handshakes: the result register frees up when empty or taken.
  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_word         <= instr_word;
      s1_address      <= instr_address;
      s1_next_word    <= next_word;
      s1_next_present <= next_present;
    end
  end

  // Decode between the two registers.
  bfp_decode u_decode (
    .instr_word    (s1_word),
    .instr_address (s1_address),
    .next_word     (s1_next_word),
    .next_present  (s1_next_present),
    .result        (dec_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
    if (s1_valid && s1_advance) begin
      out_result <= dec_result;
    end
  end

  assign flow_class          = out_result.flow_class;
  assign target_valid        = out_result.target_valid;
  assign target_word_address = out_result.target;

  // A decoded beat moves into the result register when it advances.
  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_advance |=> out_valid)
    else $error("decoded beat was not registered as a result");

  // With both registers empty the block must take input.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid && !out_valid |-> in_ready)
    else $error("empty pipeline refused input");

  // Reset empties both registers.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("valid flags survived reset");

  // Classes without a target never report one.
  a_no_target: assert property (@(posedge clk) disable iff (rst)
    out_valid && (flow_class == FLOW_NONE || flow_class == FLOW_RET)
      |-> !target_valid && target_word_address == '0)
    else $error("target reported for a class without one");

  // Conditional jumps always have a short target.
  a_cond_target: assert property (@(posedge clk) disable iff (rst)
    out_valid && flow_class == FLOW_COND |-> target_valid)
    else $error("conditional jump without target");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the branch flow predecoder: a directed table of
// opcodes, then random beats with idling and back-pressure on both channels.
// Depends on bfp_pkg and branch_flow_predecode.
module tb_top
  import bfp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BEATS = 1200;
  localparam int CALM_BEATS   = 150;
  localparam int PAUSE_AT     = 600;
  localparam int LONG_HOLD    = 80;
  localparam int HOLD_AFTER   = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 400000;

  // One stimulus row; want is used only when typed is set.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] nw;
    logic              have;
    logic              typed;
    bfp_result_t       want;
  } flow_row_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [WORD_W-1:0] instr_word;
  logic [ADDR_W-1:0] instr_address;
  logic [WORD_W-1:0] next_word;
  logic              next_present;
  logic              out_valid;
  logic              out_ready;
  logic [2:0]        flow_class;
  logic              target_valid;
  logic [ADDR_W-1:0] target_word_address;

  bfp_result_t flow_expected [$];
  int          mismatch_count = 0;
  int          results_seen   = 0;
  int          cycle_count    = 0;
  bit          calm           = 1'b0;

  logic [WORD_W-1:0] cond_codes [0:5] = '{COND_0, COND_4, COND_5, COND_7, COND_9, COND_B};

  // Directed rows: extremes, every opcode family, missing next word, near misses.
  flow_row_t dir_rows [0:24] = '{
    '{16'h0000, 22'h000000, 16'h0000, 1'b0, 1'b1, '{FLOW_NONE, 1'b0, 22'h000000}},
    '{16'hFFFF, 22'h3FFFFF, 16'hFFFF, 1'b1, 1'b1, '{FLOW_NONE, 1'b0, 22'h000000}},
    '{RET_SUB,  22'h155555, 16'hAAAA, 1'b1, 1'b1, '{FLOW_RET,  1'b0, 22'h000000}},
    '{RET_INT,  22'h3FFFFF, 16'hFFFF, 1'b1, 1'b1, '{FLOW_RET,  1'b0, 22'h000000}},
    '{JMP_SHORT | 16'h003F, 22'h3FFFFF, 16'h0000, 1'b0, 1'b1,
      '{FLOW_JUMP, 1'b1, 22'h00003F}},
    '{JMP_SHORT | 16'h007F, 22'h000000, 16'h0000, 1'b0, 1'b1,
      '{FLOW_JUMP, 1'b1, 22'h3FFFC2}},
    '{JMP_SHORT, 22'h001234, 16'h5555, 1'b1, 1'b0, '0},
    '{COND_0 | 16'h0015, 22'h2AAAAA, 16'h0F0F, 1'b1, 1'b0, '0},
    '{COND_4 | 16'h0041, 22'h100000, 16'hF0F0, 1'b0, 1'b0, '0},
    '{COND_5 | 16'h007F, 22'h000000, 16'h0001, 1'b1, 1'b0, '0},
    '{COND_7 | 16'h003F, 22'h3FFFFE, 16'h8000, 1'b1, 1'b0, '0},
    '{COND_9 | 16'h0040, 22'h0ABCDE, 16'h1234, 1'b0, 1'b0, '0},
    '{COND_B | 16'h0020, 22'h00FFDF, 16'h4321, 1'b1, 1'b0, '0},
    '{JMP_LONG, 22'h3FFFFF, 16'hFFFF, 1'b1, 1'b1, '{FLOW_JUMP, 1'b1, 22'h00FFFF}},
    '{JMP_LONG, 22'h12FFFF, 16'h1234, 1'b1, 1'b0, '0},
    '{JMP_LONG, 22'h2ABCDE, 16'hBEEF, 1'b0, 1'b1, '{FLOW_JUMP, 1'b0, 22'h000000}},
    '{CALL_CODE | 16'h003F, 22'h000000, 16'hFFFF, 1'b1, 1'b1,
      '{FLOW_CALL, 1'b1, 22'h3FFFFF}},
    '{16'hFE40, 22'h3FFFFF, 16'h0000, 1'b1, 1'b0, '0},
    '{CALL_CODE, 22'h012345, 16'hCAFE, 1'b0, 1'b1, '{FLOW_CALL, 1'b0, 22'h000000}},
    '{GOTO_CODE | 16'h003F, 22'h000000, 16'hFFFF, 1'b1, 1'b1,
      '{FLOW_JUMP, 1'b1, 22'h3FFFFF}},
    '{GOTO_CODE, 22'h3FFFFF, 16'h5A5A, 1'b0, 1'b1, '{FLOW_JUMP, 1'b0, 22'h000000}},
    '{16'h9A91, 22'h000010, 16'h0000, 1'b1, 1'b1, '{FLOW_NONE, 1'b0, 22'h000000}},
    '{16'hEE80, 22'h000020, 16'h0000, 1'b1, 1'b1, '{FLOW_NONE, 1'b0, 22'h000000}},
    '{16'h9F0E, 22'h000030, 16'hFFFF, 1'b1, 1'b1, '{FLOW_NONE, 1'b0, 22'h000000}},
    '{16'hFEC0, 22'h000040, 16'hFFFF, 1'b1, 1'b1, '{FLOW_NONE, 1'b0, 22'h000000}}
  };

  branch_flow_predecode u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .instr_word          (instr_word),
    .instr_address       (instr_address),
    .next_word           (next_word),
    .next_present        (next_present),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .flow_class          (flow_class),
    .target_valid        (target_valid),
    .target_word_address (target_word_address)
  );

  // Clock with a 4 ns period.
  always #2 clk = ~clk;

  // Computes the flow class and target of one instruction beat.
  function automatic bfp_result_t predict_flow(input logic [WORD_W-1:0] w,
                                               input logic [ADDR_W-1:0] addr,
                                               input logic [WORD_W-1:0] nw,
                                               input logic have);
    bfp_result_t       r;
    logic [ADDR_W-1:0] nxt;
    logic [ADDR_W-1:0] offs;
    logic [WORD_W-1:0] op;
    r    = '{flow_class: FLOW_NONE, target_valid: 1'b0, target: '0};
    nxt  = addr + 22'd1;
    offs = {16'd0, w[OFFS_W-1:0]};
    op   = w & SHORT_MASK;
    if (op == JMP_SHORT || op inside {COND_0, COND_4, COND_5, COND_7, COND_9, COND_B}) begin
      r.flow_class   = (op == JMP_SHORT) ? FLOW_JUMP : FLOW_COND;
      r.target_valid = 1'b1;
      r.target       = w[6] ? nxt - offs : nxt + offs;
    end else if (w == RET_SUB || w == RET_INT) begin
      r.flow_class = FLOW_RET;
    end else if (w == JMP_LONG) begin
      r.flow_class = FLOW_JUMP;
      if (have) begin
        r.target_valid = 1'b1;
        r.target       = {nxt[ADDR_W-1:16], nw};
      end
    end else if ((w & CALL_MASK) == CALL_CODE || (w & GOTO_MASK) == GOTO_CODE) begin
      r.flow_class = ((w & CALL_MASK) == CALL_CODE) ? FLOW_CALL : FLOW_JUMP;
      if (have) begin
        r.target_valid = 1'b1;
        r.target       = {w[OFFS_W-1:0], nw};
      end
    end
    return r;
  endfunction

  // Random beat, weighted toward the flow opcodes with random operand bits.
  function automatic flow_row_t random_row();
    flow_row_t   row;
    logic [15:0] rnd;
    rnd      = 16'($urandom);
    row      = '0;
    row.nw   = 16'($urandom);
    row.have = ($urandom_range(0, 4) != 0);
    case ($urandom_range(0, 3))
      0:       row.addr = 22'h3FFFFF - 22'($urandom_range(0, 70));
      1:       row.addr = 22'($urandom_range(0, 70));
      2:       row.addr = {6'($urandom), 16'hFFFF - 16'($urandom_range(0, 70))};
      default: row.addr = 22'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       row.word = JMP_SHORT | (rnd & ~SHORT_MASK);
      1, 2:    row.word = cond_codes[$urandom_range(0, 5)] | (rnd & ~SHORT_MASK);
      3:       row.word = rnd[0] ? RET_INT : RET_SUB;
      4:       row.word = JMP_LONG;
      5:       row.word = CALL_CODE | (rnd & ~CALL_MASK);
      6:       row.word = GOTO_CODE | (rnd & ~GOTO_MASK);
      default: row.word = rnd;
    endcase
    return row;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // Offers one beat and holds it until accepted, then records its expected result.
  task automatic drive_beat(input flow_row_t row, input bfp_result_t want);
    in_valid      <= 1'b1;
    instr_word    <= row.word;
    instr_address <= row.addr;
    next_word     <= row.nw;
    next_present  <= row.have;
    do @(posedge clk); while (!in_ready);
    flow_expected.push_back(want);
  endtask

  // Random sender gap after a beat, skipped in the calm phase.
  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Result checker: compares every accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    bfp_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (flow_expected.size() == 0) begin
        report_mismatch("result beat with nothing expected", 32'(flow_class), 32'd0);
      end else begin
        want = flow_expected.pop_front();
        if (flow_class !== want.flow_class)
          report_mismatch("flow_class", 32'(flow_class), 32'(want.flow_class));
        if (target_valid !== want.target_valid)
          report_mismatch("target_valid", 32'(target_valid), 32'(want.target_valid));
        if (target_word_address !== want.target)
          report_mismatch("target_word_address", 32'(target_word_address),
                          32'(want.target));
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random ready bursts, one long hold-off, always ready when calm.
  initial begin : sink_ctrl
    int  hold;
    bit  held_long;
    held_long = 1'b0;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!calm && !held_long && results_seen >= HOLD_AFTER) begin
        held_long = 1'b1;
        out_ready <= 1'b0;
        for (hold = 0; hold < LONG_HOLD; hold++) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Sender: reset, directed table, random beats, then drain and verdict.
  initial begin : source_ctrl
    flow_row_t row;
    int        idx;
    clk           = 1'b0;
    rst           = 1'b1;
    in_valid      = 1'b0;
    instr_word    = '0;
    instr_address = '0;
    next_word     = '0;
    next_present  = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: typed expectations where obvious, otherwise predicted.
    for (idx = 0; idx < $size(dir_rows); idx++) begin
      row = dir_rows[idx];
      drive_beat(row, row.typed ? row.want
                                : predict_flow(row.word, row.addr, row.nw, row.have));
      maybe_idle();
    end

    // Random beats, with one pause that lets the pipeline drain completely.
    for (idx = 0; idx < RANDOM_BEATS; idx++) begin
      calm = (idx >= RANDOM_BEATS - CALM_BEATS);
      if (idx == PAUSE_AT) begin
        in_valid <= 1'b0;
        while (flow_expected.size() != 0) @(posedge clk);
      end
      row = random_row();
      drive_beat(row, predict_flow(row.word, row.addr, row.nw, row.have));
      maybe_idle();
    end
    in_valid <= 1'b0;

    while (flow_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
